@@ rtl/bilinear_remap_pixel_sampler_top_macros.svh @@
// Assertion macros shared by the bilinear remap sampler RTL.
// Included by the modules that carry concurrent assertions; needs aclk and aresetn in scope.
`ifndef BILINEAR_REMAP_PIXEL_SAMPLER_TOP_MACROS_SVH
`define BILINEAR_REMAP_PIXEL_SAMPLER_TOP_MACROS_SVH

// Same-cycle implication, sampled on aclk and off while aresetn is low.
`define BRPS_ASSERT_SAME(label, cond, rule, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |-> (rule)) else $error(msg);

// Next-cycle implication, sampled on aclk and off while aresetn is low.
`define BRPS_ASSERT_NEXT(label, cond, rule, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |=> (rule)) else $error(msg);

`endif

@@ rtl/brps_pkg.sv @@
// Package of the bilinear remap sampler: item types, codes, constants, blend functions.
// Used by every RTL module of the block but brps_ram; depends on nothing.
`default_nettype none

package brps_pkg;

    // Defaults for the top-level parameters.
    localparam int SOURCE_PIXELS_DEF = 65536;
    localparam int MAX_WIDTH_DEF     = 4096;
    localparam int QUEUE_DEPTH_DEF   = 2;

    // The pixel index is 16 bits wide, so the store never holds more than this.
    localparam int STORE_MAX = 65536;

    localparam int INDEX_W    = 16;
    localparam int WIDTH_W    = 13;
    localparam int CFG_DATA_W = 13;
    localparam int PIX_W      = 32;
    localparam int FRAC_W     = 16;
    localparam int HSUM_W     = 24;
    localparam int NUM_PLANES = 4;
    localparam int NUM_TAPS   = 4;

    // Operation codes of an input item.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    // Configuration register indexes.
    localparam logic REG_ROW_STRIDE  = 1'b0;
    localparam logic REG_OUTPUT_MODE = 1'b1;

    typedef enum logic [1:0] {
        MODE_LUMA = 2'd0,
        MODE_YUV  = 2'd1,
        MODE_YUVA = 2'd2,
        MODE_YUYV = 2'd3
    } mode_t;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd256;
    localparam mode_t              MODE_RESET  = MODE_YUV;

    // Pixel of an entry that maps outside the mesh, packed Y, U, V, A from the low byte.
    localparam logic [PIX_W-1:0] BLACK_PIXEL = {8'd0, 8'd128, 8'd128, 8'd0};

    // Rounding constant of the vertical blend (one half at bit 32).
    localparam logic signed [41:0] ROUND_HALF = 42'sh0080000000;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_BLACK  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        logic               operation;
        logic [15:0]        pixel_index;
        logic [7:0]         write_luma;
        logic [7:0]         write_cb;
        logic [7:0]         write_cr;
        logic [7:0]         write_alpha;
        logic               entry_valid;
        logic               has_right;
        logic               has_down;
        logic [15:0]        frac_x;
        logic [15:0]        frac_y;
        logic               row_tail;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_luma;
        logic [7:0] out_cb;
        logic [7:0] out_cr;
        logic [7:0] out_alpha;
        logic [7:0] out_luma_second;
        logic       single_pixel;
    } out_item_t;

    // Configuration seen by the back end.
    typedef struct packed {
        mode_t output_mode;
        logic  mode_wr;
    } cfg_t;

    // One classified command in the queue between front and back end.
    typedef struct packed {
        cmd_kind_t                            kind;
        logic [NUM_TAPS-1:0][INDEX_W-1:0]     addr;
        logic [NUM_TAPS-1:0]                  zero;
        logic [PIX_W-1:0]                     pixel;
        logic [FRAC_W-1:0]                    frac_x;
        logic [FRAC_W-1:0]                    frac_y;
        logic                                 row_tail;
    } cmd_t;

    // Horizontal blend a*(65536-f) + b*f, written as a*65536 + (b-a)*f.
    function automatic logic [HSUM_W-1:0] lerp_h(input logic [7:0] a, input logic [7:0] b,
                                                 input logic [FRAC_W-1:0] f);
        logic signed [8:0]  d;
        logic signed [25:0] s;
        d = $signed({1'b0, b}) - $signed({1'b0, a});
        s = $signed({2'b00, a, 16'h0000}) + d * $signed({1'b0, f});
        return s[HSUM_W-1:0];
    endfunction

    // Vertical blend of two row sums with rounding, the byte above the 32-bit fraction.
    function automatic logic [7:0] lerp_v(input logic [HSUM_W-1:0] t,
                                          input logic [HSUM_W-1:0] b,
                                          input logic [FRAC_W-1:0] f);
        logic signed [24:0] d;
        logic signed [41:0] acc;
        d   = $signed({1'b0, b}) - $signed({1'b0, t});
        acc = $signed({2'b00, t, 16'h0000}) + d * $signed({1'b0, f}) + ROUND_HALF;
        return acc[39:32];
    endfunction

endpackage

`default_nettype wire

@@ rtl/bilinear_remap_pixel_sampler_top.sv @@
// Top level of the bilinear remap sampler: front end, command queue, back end.
// Depends on brps_pkg, brps_front, brps_queue and brps_back.
//
//   Port group   Direction  Handshake          Carries
//   s_*          in         s_valid / s_ready  in_item_t: store write or map entry
//   m_*          out        m_valid / m_ready  out_item_t: sampled or packed pixel
//   cfg_*        in         cfg_we             row stride (0), output mode (1)
//
// A render item holds the single store port for a read of each of its four neighbors in turn;
// a write item takes the port once and an entry outside the mesh not at all. A mapped entry
// passes the queue, store reads, blend and packing registers, then the output register.
// aresetn is synchronous and clears control state; the pixel store is not cleared.
// A queue of QUEUE_DEPTH commands and the output register let input and output stall
// independently.
`default_nettype none

module bilinear_remap_pixel_sampler_top import brps_pkg::*; #(
    parameter int SOURCE_PIXELS = SOURCE_PIXELS_DEF,
    parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data
);

    cfg_t cfg;
    logic q_push, q_full, q_pop, q_empty;
    cmd_t q_data, q_head;

    // Accept, classify and address.
    brps_front #(
        .SOURCE_PIXELS (SOURCE_PIXELS),
        .MAX_WIDTH     (MAX_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_data)
    );

    // Decoupling queue.
    brps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    // Store access, blend and packing.
    brps_back #(
        .SOURCE_PIXELS (SOURCE_PIXELS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

@@ rtl/brps_ram.sv @@
// Generic single-port RAM with registered read data.
// Standalone; used for the source pixel store.
`default_nettype none

module brps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One access per cycle; read data holds until the next read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/brps_front.sv @@
// Front end: configuration registers, input acceptance, neighbor address forming.
// Depends on brps_pkg; feeds classified commands to brps_queue.
`default_nettype none

module brps_front import brps_pkg::*; #(
    parameter int SOURCE_PIXELS = SOURCE_PIXELS_DEF,
    parameter int MAX_WIDTH     = MAX_WIDTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                       cfg,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,
    input  wire logic                  q_full,
    output logic                       q_push,
    output cmd_t                       q_data
);

    localparam int Depth = (SOURCE_PIXELS < STORE_MAX) ? SOURCE_PIXELS : STORE_MAX;

    logic [WIDTH_W-1:0]              width_reg;
    mode_t                           mode_reg;
    logic [WIDTH_W-1:0]              stride;
    logic [WIDTH_W-1:0]              down;
    logic [NUM_TAPS-1:0][INDEX_W:0]  nb_addr;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= WIDTH_RESET;
            mode_reg  <= MODE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ROW_STRIDE:  width_reg <= cfg_wdata[WIDTH_W-1:0];
                REG_OUTPUT_MODE: mode_reg  <= mode_t'(cfg_wdata[1:0]);
            endcase
        end
    end

    assign cfg.output_mode = mode_reg;
    assign cfg.mode_wr     = cfg_we && (cfg_index == REG_OUTPUT_MODE);

    // Items enter the queue whenever it has room.
    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    // Form the four neighbor addresses and flag the ones outside the store.
    always_comb begin
        stride = (32'(width_reg) > 32'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : width_reg;
        down   = s_data.has_down ? stride : '0;
        nb_addr[0] = {1'b0, s_data.pixel_index};
        nb_addr[1] = nb_addr[0] + 17'(s_data.has_right);
        nb_addr[2] = nb_addr[0] + {4'd0, down};
        nb_addr[3] = nb_addr[2] + 17'(s_data.has_right);
        for (int k = 0; k < NUM_TAPS; k++) begin
            q_data.addr[k] = nb_addr[k][INDEX_W-1:0];
            q_data.zero[k] = {15'd0, nb_addr[k]} >= 32'(Depth);
        end
        if (s_data.operation == OP_WRITE) begin
            q_data.kind = CMD_WRITE;
        end else if (s_data.entry_valid) begin
            q_data.kind = CMD_SAMPLE;
        end else begin
            q_data.kind = CMD_BLACK;
        end
        q_data.pixel    = {s_data.write_alpha, s_data.write_cr, s_data.write_cb,
                           s_data.write_luma};
        q_data.frac_x   = s_data.frac_x;
        q_data.frac_y   = s_data.frac_y;
        q_data.row_tail = s_data.row_tail;
    end

endmodule

`default_nettype wire

@@ rtl/brps_queue.sv @@
// Short command queue between the front end and the back end.
// Depends on brps_pkg for the command type.
`default_nettype none

module brps_queue import brps_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_data,
    output logic      full,
    input  wire logic pop,
    output cmd_t      head,
    output logic      empty
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);

    cmd_t            slot_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;

    assign full  = (count_reg == CntW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    // Slot storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/brps_back.sv @@
// Back end: store port sequencing, bilinear blend pipeline, YUYV packing, output register.
// Depends on brps_pkg, brps_ram and the assertion macro header.
`default_nettype none
`include "bilinear_remap_pixel_sampler_top_macros.svh"

module brps_back import brps_pkg::*; #(
    parameter int SOURCE_PIXELS = SOURCE_PIXELS_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire cfg_t cfg,
    input  wire logic q_empty,
    input  wire cmd_t q_head,
    output logic      q_pop,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_item_t m_data
);

    localparam int Depth = (SOURCE_PIXELS < STORE_MAX) ? SOURCE_PIXELS : STORE_MAX;
    localparam int Aw    = $clog2(Depth);
    localparam logic [1:0] StepFirst = 2'd1;
    localparam logic [1:0] StepLast  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_FIN  = 3'b100
    } rd_state_t;

    rd_state_t                          state_reg, state_next;
    logic [1:0]                         step_reg, step_next;
    cmd_t                               cmd_reg;
    logic [PIX_W-1:0]                   p0_reg;
    logic [NUM_PLANES-1:0][HSUM_W-1:0]  top_reg;
    logic                               v_vld_reg;
    logic [NUM_PLANES-1:0][HSUM_W-1:0]  v_top_reg;
    logic [NUM_PLANES-1:0][HSUM_W-1:0]  v_bot_reg;
    logic [FRAC_W-1:0]                  v_fy_reg;
    logic                               v_tail_reg;
    logic                               p_vld_reg;
    logic [PIX_W-1:0]                   p_pix_reg;
    logic                               p_tail_reg;
    logic                               m_valid_reg;
    out_item_t                          m_data_reg;
    logic                               pend_flag_reg, pend_flag_next;
    logic [23:0]                        pend_pix_reg, pend_pix_next;

    logic                               p_adv, v_adv, v_free, fin_go, reader_free;
    logic                               launch_write, launch_sample, launch_black;
    logic                               v_load, p_fire, emit;
    logic                               ram_we, ram_re;
    logic [Aw-1:0]                      ram_addr;
    logic [PIX_W-1:0]                   ram_rdata;
    logic                               rd_zero;
    logic [PIX_W-1:0]                   rd_px;
    logic [NUM_PLANES-1:0][HSUM_W-1:0]  h_lane;
    logic [NUM_PLANES-1:0][HSUM_W-1:0]  black_sum;
    logic [PIX_W-1:0]                   v_pix;
    out_item_t                          out_next;
    logic [8:0]                         sum_u, sum_v;

    // Handshake between the pipeline stages, from the output backwards.
    assign p_adv       = !m_valid_reg || m_ready;
    assign v_adv       = !p_vld_reg || p_adv;
    assign v_free      = !v_vld_reg || v_adv;
    assign fin_go      = (state_reg == ST_FIN) && v_free;
    assign reader_free = (state_reg == ST_IDLE) || fin_go;

    // Pop the next command when the store port and the stage it needs are free.
    assign launch_write  = reader_free && !q_empty && (q_head.kind == CMD_WRITE);
    assign launch_sample = reader_free && !q_empty && (q_head.kind == CMD_SAMPLE);
    assign launch_black  = (state_reg == ST_IDLE) && v_free && !q_empty &&
                           (q_head.kind == CMD_BLACK);
    assign q_pop         = launch_write || launch_sample || launch_black;
    assign v_load        = fin_go || launch_black;

    // Store port: one write, or one of the four neighbor reads, per cycle.
    assign ram_we = launch_write && !q_head.zero[0];
    assign ram_re = launch_sample || (state_reg == ST_READ);
    assign ram_addr = (state_reg == ST_READ) ? cmd_reg.addr[step_reg][Aw-1:0]
                                             : q_head.addr[0][Aw-1:0];

    brps_ram #(
        .WIDTH (PIX_W),
        .DEPTH (Depth)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (q_head.pixel),
        .rdata (ram_rdata)
    );

    // Neighbors outside the store read as zero.
    always_comb begin
        rd_zero = (state_reg == ST_FIN) ? cmd_reg.zero[NUM_TAPS-1]
                                        : cmd_reg.zero[step_reg - 2'd1];
        rd_px   = rd_zero ? '0 : ram_rdata;
        for (int c = 0; c < NUM_PLANES; c++) begin
            h_lane[c]    = lerp_h(p0_reg[8*c +: 8], rd_px[8*c +: 8], cmd_reg.frac_x);
            black_sum[c] = {BLACK_PIXEL[8*c +: 8], 16'h0000};
            v_pix[8*c +: 8] = lerp_v(v_top_reg[c], v_bot_reg[c], v_fy_reg);
        end
    end

    // Read sequencer.
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (launch_sample) begin
                    state_next = ST_READ;
                    step_next  = StepFirst;
                end
            end
            ST_READ: begin
                if (step_reg == StepLast) begin
                    state_next = ST_FIN;
                end else begin
                    step_next = step_reg + 2'd1;
                end
            end
            ST_FIN: begin
                if (fin_go) begin
                    state_next = launch_sample ? ST_READ : ST_IDLE;
                    step_next  = StepFirst;
                end
            end
            default: begin
                state_next = ST_IDLE;
                step_next  = StepFirst;
            end
        endcase
    end

    // Output packing for the pixel leaving the last blend stage.
    assign p_fire = p_vld_reg && p_adv;

    always_comb begin
        out_next       = '0;
        emit           = 1'b0;
        pend_flag_next = pend_flag_reg;
        pend_pix_next  = pend_pix_reg;
        sum_u          = {1'b0, pend_pix_reg[15:8]} + {1'b0, p_pix_reg[15:8]};
        sum_v          = {1'b0, pend_pix_reg[23:16]} + {1'b0, p_pix_reg[23:16]};
        if (p_fire) begin
            unique case (cfg.output_mode)
                MODE_YUYV: begin
                    if (p_tail_reg) begin
                        out_next.out_luma     = p_pix_reg[7:0];
                        out_next.out_cb       = p_pix_reg[15:8];
                        out_next.single_pixel = 1'b1;
                        pend_flag_next        = 1'b0;
                        emit                  = 1'b1;
                    end else if (!pend_flag_reg) begin
                        pend_pix_next  = p_pix_reg[23:0];
                        pend_flag_next = 1'b1;
                    end else begin
                        out_next.out_luma        = pend_pix_reg[7:0];
                        out_next.out_cb          = sum_u[8:1];
                        out_next.out_cr          = sum_v[8:1];
                        out_next.out_luma_second = p_pix_reg[7:0];
                        pend_flag_next           = 1'b0;
                        emit                     = 1'b1;
                    end
                end
                MODE_LUMA: begin
                    out_next.out_luma = p_pix_reg[7:0];
                    emit              = 1'b1;
                end
                MODE_YUV: begin
                    out_next.out_luma = p_pix_reg[7:0];
                    out_next.out_cb   = p_pix_reg[15:8];
                    out_next.out_cr   = p_pix_reg[23:16];
                    emit              = 1'b1;
                end
                MODE_YUVA: begin
                    out_next.out_luma  = p_pix_reg[7:0];
                    out_next.out_cb    = p_pix_reg[15:8];
                    out_next.out_cr    = p_pix_reg[23:16];
                    out_next.out_alpha = p_pix_reg[31:24];
                    emit               = 1'b1;
                end
            endcase
        end
        if (cfg.mode_wr) begin
            pend_flag_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= StepFirst;
            v_vld_reg     <= 1'b0;
            p_vld_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
            pend_flag_reg <= 1'b0;
            pend_pix_reg  <= '0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            pend_flag_reg <= pend_flag_next;
            pend_pix_reg  <= pend_pix_next;
            if (v_load) begin
                v_vld_reg <= 1'b1;
            end else if (v_adv) begin
                v_vld_reg <= 1'b0;
            end
            if (v_vld_reg && v_adv) begin
                p_vld_reg <= 1'b1;
            end else if (p_adv) begin
                p_vld_reg <= 1'b0;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (launch_sample) begin
            cmd_reg <= q_head;
        end
        if (state_reg == ST_READ) begin
            if (step_reg == 2'd2) begin
                top_reg <= h_lane;
            end else begin
                p0_reg <= rd_px;
            end
        end
        if (fin_go) begin
            v_top_reg  <= top_reg;
            v_bot_reg  <= h_lane;
            v_fy_reg   <= cmd_reg.frac_y;
            v_tail_reg <= cmd_reg.row_tail;
        end else if (launch_black) begin
            v_top_reg  <= black_sum;
            v_bot_reg  <= black_sum;
            v_fy_reg   <= q_head.frac_y;
            v_tail_reg <= q_head.row_tail;
        end
        if (v_vld_reg && v_adv) begin
            p_pix_reg  <= v_pix;
            p_tail_reg <= v_tail_reg;
        end
        if (emit) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `BRPS_ASSERT_SAME(a_port_exclusive, ram_we, !ram_re, "store written and read in one cycle")
    `BRPS_ASSERT_SAME(a_vstage_free, v_load, v_free, "blend stage loaded while still held")
    `BRPS_ASSERT_SAME(a_pop_nonempty, q_pop, !q_empty, "command popped from an empty queue")
    `BRPS_ASSERT_SAME(a_pend_mode, pend_flag_reg, cfg.output_mode == MODE_YUYV, "pair pending outside YUYV mode")

endmodule

`default_nettype wire

@@ sim/tb_bilinear_remap_pixel_sampler_top.sv @@
// Self-checking testbench of the bilinear remap sampler: directed and random store writes
// and map-entry renders, checked against an in-bench predictor. Depends on brps_pkg and the RTL.
`default_nettype none

module tb_bilinear_remap_pixel_sampler_top import brps_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STORE_SIZE    = 65536;
    localparam int unsigned WIDTH_CAP     = 4096;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          SETTLE_CYCLES = 24;
    // Longest correct stretch without an accepted item is the hold-off plus a long gap
    // and the pipeline latency.
    localparam int          IDLE_LIMIT    = 4000;
    localparam int          RANDOM_PHASES = 8;
    localparam int          PHASE_ITEMS   = 50;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic                  cfg_index = 1'b0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;

    // Mirror of the source frame store and of the sampler's registers.
    bit [31:0]   src_mirror [STORE_SIZE];
    bit          src_loaded [STORE_SIZE];
    bit [12:0]   width_reg  = 13'd256;
    mode_t       mode_reg   = MODE_YUV;
    bit [23:0]   held_pixel = '0;
    bit          held_valid = 1'b0;

    out_item_t   pixels_due [$];
    int unsigned bad_count    = 0;
    bit          calm         = 1'b0;
    bit          hold_request = 1'b0;
    bit [15:0]   hot_base     = 16'd1000;

    bilinear_remap_pixel_sampler_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic string pixel_text(input out_item_t p);
        return $sformatf("Y=%0d U=%0d V=%0d A=%0d Y2=%0d single=%0d", p.out_luma, p.out_cb,
                         p.out_cr, p.out_alpha, p.out_luma_second, p.single_pixel);
    endfunction

    function automatic void note_failure(input string msg);
        bad_count++;
        if (bad_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    // Source index of one of the four taps: 0 top-left, 1 right, 2 down, 3 down-right.
    function automatic bit [31:0] tap_addr(input in_item_t it, input int k);
        bit [31:0] stride;
        bit [31:0] down;
        stride = (width_reg > WIDTH_CAP) ? WIDTH_CAP : width_reg;
        down   = it.has_down ? stride : 32'd0;
        return it.pixel_index + ((k & 1) ? 32'(it.has_right) : 32'd0) + ((k & 2) ? down : 32'd0);
    endfunction

    // Taps past the end of the store read as zero.
    function automatic bit [31:0] fetch_pixel(input bit [31:0] addr);
        return (addr < STORE_SIZE) ? src_mirror[addr] : 32'd0;
    endfunction

    // One plane of the 16.16 bilinear blend, rounded at bit 31, top byte kept.
    function automatic bit [7:0] blend_plane(input bit [7:0] p00, input bit [7:0] p10,
                                             input bit [7:0] p01, input bit [7:0] p11,
                                             input bit [15:0] fx, input bit [15:0] fy);
        bit [63:0] wx0, wy0, top, bottom, acc;
        wx0    = 64'd65536 - fx;
        wy0    = 64'd65536 - fy;
        top    = p00 * wx0 + p10 * fx;
        bottom = p01 * wx0 + p11 * fx;
        acc    = top * wy0 + bottom * fy + (64'd1 << 31);
        return acc[39:32];
    endfunction

    // Sampled pixel of a map entry, packed Y, U, V, A from the low byte.
    function automatic bit [31:0] sample_point(input in_item_t it);
        bit [31:0] px [4];
        bit [31:0] result;
        int        k;
        if (!it.entry_valid) return {8'd0, 8'd128, 8'd128, 8'd0};
        for (k = 0; k < 4; k++) px[k] = fetch_pixel(tap_addr(it, k));
        for (k = 0; k < 4; k++)
            result[k*8 +: 8] = blend_plane(px[0][k*8 +: 8], px[1][k*8 +: 8], px[2][k*8 +: 8],
                                           px[3][k*8 +: 8], it.frac_x, it.frac_y);
        return result;
    endfunction

    // Applies one accepted item to the mirror; returns 1 with the pixel it sends out.
    function automatic bit remap_item(input in_item_t it, output out_item_t px_out);
        bit [31:0] p;
        bit [8:0]  sum;
        px_out = '0;
        if (it.operation == OP_WRITE) begin
            src_mirror[it.pixel_index] = {it.write_alpha, it.write_cr, it.write_cb,
                                          it.write_luma};
            src_loaded[it.pixel_index] = 1'b1;
            return 1'b0;
        end
        p = sample_point(it);
        if (mode_reg == MODE_YUYV) begin
            // A row tail goes out alone and drops any half-built pair.
            if (it.row_tail) begin
                held_valid          = 1'b0;
                px_out.out_luma     = p[7:0];
                px_out.out_cb       = p[15:8];
                px_out.single_pixel = 1'b1;
                return 1'b1;
            end
            if (!held_valid) begin
                held_pixel = p[23:0];
                held_valid = 1'b1;
                return 1'b0;
            end
            held_valid             = 1'b0;
            px_out.out_luma        = held_pixel[7:0];
            sum                    = held_pixel[15:8] + p[15:8];
            px_out.out_cb          = sum[8:1];
            sum                    = held_pixel[23:16] + p[23:16];
            px_out.out_cr          = sum[8:1];
            px_out.out_luma_second = p[7:0];
            return 1'b1;
        end
        px_out.out_luma = p[7:0];
        if (mode_reg != MODE_LUMA) begin
            px_out.out_cb = p[15:8];
            px_out.out_cr = p[23:16];
        end
        if (mode_reg == MODE_YUVA) px_out.out_alpha = p[31:24];
        return 1'b1;
    endfunction

    // Unused fields of an item carry random bits.
    function automatic in_item_t random_fill();
        bit [95:0] junk;
        junk = {$urandom(), $urandom(), $urandom()};
        return junk[$bits(in_item_t)-1:0];
    endfunction

    function automatic in_item_t write_item(input bit [15:0] index, input bit [31:0] pixel);
        in_item_t it;
        it = random_fill();
        it.operation   = OP_WRITE;
        it.pixel_index = index;
        {it.write_alpha, it.write_cr, it.write_cb, it.write_luma} = pixel;
        return it;
    endfunction

    function automatic in_item_t render_item(input bit [15:0] index, input bit valid,
                                             input bit right, input bit down,
                                             input bit [15:0] fx, input bit [15:0] fy,
                                             input bit tail);
        in_item_t it;
        it = random_fill();
        it.operation   = OP_RENDER;
        it.pixel_index = index;
        it.entry_valid = valid;
        it.has_right   = right;
        it.has_down    = down;
        it.frac_x      = fx;
        it.frac_y      = fy;
        it.row_tail    = tail;
        return it;
    endfunction

    function automatic bit [15:0] rand_frac();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 16'd0;
        if (r < 16) return 16'hFFFF;
        return 16'($urandom());
    endfunction

    // Offers one item and waits until it is accepted. Valid is only lowered for a gap.
    task automatic send_item(input in_item_t it);
        int        gap;
        out_item_t px;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (remap_item(it, px)) pixels_due.push_back(px);
    endtask

    // For an entry in the mesh, loads every in-range tap that was never written, then sends the render item.
    task automatic send_render(input in_item_t it);
        bit [31:0] addr;
        int        k;
        if (it.entry_valid) begin
            for (k = 0; k < 4; k++) begin
                addr = tap_addr(it, k);
                if (addr < STORE_SIZE && !src_loaded[addr])
                    send_item(write_item(addr[15:0], $urandom()));
            end
        end
        send_item(it);
    endtask

    // Waits until every due pixel has come out and the pipeline has emptied.
    task automatic settle();
        s_valid <= 1'b0;
        while (pixels_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes the stride register, then the mode register, back to back; a mode write drops a held pixel.
    task automatic reconfigure(input bit [12:0] width, input mode_t mode);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_ROW_STRIDE;
        cfg_wdata <= width;
        @(posedge aclk);
        width_reg  = width;
        cfg_index <= REG_OUTPUT_MODE;
        cfg_wdata <= {11'($urandom()), mode};
        @(posedge aclk);
        mode_reg   = mode;
        held_valid = 1'b0;
        cfg_we    <= 1'b0;
    endtask

    // Register values out of reset: stride 256 and YUV444 output.
    task automatic test_reset_defaults();
        send_render(render_item(16'd100, 1'b1, 1'b1, 1'b1, 16'd16384, 16'd49152, 1'b0));
        send_render(render_item(16'd7000, 1'b1, 1'b0, 1'b1, rand_frac(), rand_frac(), 1'b1));
    endtask

    // Blend corners, rounding, missing neighbors, store edge and entries outside the mesh.
    task automatic test_blend_corners();
        reconfigure(13'd4096, MODE_YUVA);
        send_item(write_item(16'd0, 32'h0000_0000));
        send_item(write_item(16'd1, 32'hFFFF_FFFF));
        send_item(write_item(16'd4096, 32'hFFFF_FFFF));
        send_item(write_item(16'd4097, 32'h0000_0000));
        send_render(render_item(16'd0, 1'b1, 1'b1, 1'b1, 16'd0, 16'd0, 1'b0));
        send_render(render_item(16'd0, 1'b1, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0));
        send_render(render_item(16'd0, 1'b1, 1'b1, 1'b1, 16'h8000, 16'h8000, 1'b0));
        send_render(render_item(16'd0, 1'b1, 1'b1, 1'b1, 16'hFFFF, 16'd0, 1'b1));
        send_render(render_item(16'd0, 1'b1, 1'b0, 1'b0, rand_frac(), rand_frac(), 1'b0));
        // Right and lower neighbors of the last index fall past the store.
        send_render(render_item(16'hFFFF, 1'b1, 1'b1, 1'b1, rand_frac(), rand_frac(), 1'b0));
        send_render(render_item(16'($urandom()), 1'b0, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0));
    endtask

    // Luma-only and plain YUV444 output.
    task automatic test_output_modes();
        reconfigure(13'd4096, MODE_LUMA);
        send_render(render_item(16'd0, 1'b1, 1'b1, 1'b1, 16'h4000, 16'hC000, 1'b0));
        send_render(render_item(16'd9, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0));
        reconfigure(13'd4096, MODE_YUV);
        send_render(render_item(16'd0, 1'b1, 1'b1, 1'b1, 16'h4000, 16'hC000, 1'b1));
    endtask

    // Packed YUYV: pairs, a lone tail, a tail that drops a held pixel, black pairs,
    // and a mode write that drops a held pixel.
    task automatic test_yuyv_packing();
        reconfigure(13'd64, MODE_YUYV);
        send_render(render_item(16'd300, 1'b1, 1'b1, 1'b1, rand_frac(), rand_frac(), 1'b0));
        send_render(render_item(16'd301, 1'b1, 1'b1, 1'b1, rand_frac(), rand_frac(), 1'b0));
        send_render(render_item(16'd302, 1'b1, 1'b1, 1'b0, rand_frac(), rand_frac(), 1'b1));
        send_render(render_item(16'd303, 1'b1, 1'b0, 1'b1, rand_frac(), rand_frac(), 1'b0));
        send_render(render_item(16'd304, 1'b1, 1'b1, 1'b1, rand_frac(), rand_frac(), 1'b1));
        send_render(render_item(16'd5, 1'b0, 1'b1, 1'b1, rand_frac(), rand_frac(), 1'b0));
        send_render(render_item(16'd6, 1'b0, 1'b0, 1'b0, rand_frac(), rand_frac(), 1'b0));
        send_render(render_item(16'd305, 1'b1, 1'b1, 1'b1, rand_frac(), rand_frac(), 1'b0));
        reconfigure(13'd64, MODE_YUYV);
        send_render(render_item(16'd306, 1'b1, 1'b1, 1'b1, rand_frac(), rand_frac(), 1'b0));
        send_render(render_item(16'd307, 1'b1, 1'b1, 1'b1, rand_frac(), rand_frac(), 1'b0));
    endtask

    // Stride of zero reuses the row, an oversized stride saturates, stride one.
    task automatic test_width_extremes();
        reconfigure(13'd0, MODE_YUV);
        send_render(render_item(16'd2000, 1'b1, 1'b1, 1'b1, rand_frac(), rand_frac(), 1'b0));
        reconfigure(13'h1FFF, MODE_YUV);
        send_render(render_item(16'd2200, 1'b1, 1'b1, 1'b1, rand_frac(), rand_frac(), 1'b0));
        reconfigure(13'd1, MODE_YUV);
        send_render(render_item(16'd2400, 1'b1, 1'b1, 1'b1, rand_frac(), rand_frac(), 1'b0));
    endtask

    // The receiver holds off for a long time while items keep coming back to back.
    task automatic test_backpressure();
        int n;
        reconfigure(13'd16, MODE_YUVA);
        calm         = 1'b1;
        hold_request = 1'b1;
        for (n = 0; n < 30; n++)
            send_render(render_item(16'(hot_base + $urandom_range(0, 31)), 1'b1,
                                    1'($urandom()), 1'($urandom()), rand_frac(), rand_frac(),
                                    1'b0));
        calm = 1'b0;
    endtask

    // One random item: mostly renders around a reused window, some anywhere or at the
    // store's end, plus stray writes.
    task automatic random_item();
        bit [15:0] base;
        bit        tail;
        int        r;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            send_item(write_item(16'($urandom()), $urandom()));
            return;
        end
        r = $urandom_range(0, 99);
        if (r < 50) base = 16'(hot_base + $urandom_range(0, 47));
        else if (r < 80) base = 16'($urandom());
        else base = 16'(16'hFFFF - $urandom_range(0, 320));
        if (mode_reg == MODE_YUYV) tail = ($urandom_range(0, 99) < 15);
        else tail = 1'($urandom());
        send_render(render_item(base, $urandom_range(0, 99) < 85, 1'($urandom()),
                                1'($urandom()), rand_frac(), rand_frac(), tail));
    endtask

    // Random phases over stride and mode settings, each extreme among them.
    task automatic test_random();
        int        phase, n;
        bit [12:0] width;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: width = 13'd1;
                1: width = 13'd4096;
                2: width = 13'h1FFF;
                3: width = 13'd0;
                4: width = 13'($urandom_range(4097, 8190));
                default: width = 13'($urandom_range(2, 300));
            endcase
            reconfigure(width, mode_t'(phase[1:0]));
            hot_base = 16'($urandom_range(0, 60000));
            calm     = (phase == 5);
            for (n = 0; n < PHASE_ITEMS; n++) random_item();
            calm = 1'b0;
        end
    endtask

    // Receiver: random stalls, and a long hold-off when one is requested.
    initial begin : receiver
        int stall;
        forever begin
            @(posedge aclk);
            stall = 0;
            if (hold_request) begin
                hold_request = 1'b0;
                stall        = HOLD_CYCLES;
            end else if (!calm && $urandom_range(0, 99) < 20) begin
                stall = pick_gap();
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Each output item is compared with the oldest pixel due.
    always @(posedge aclk) begin : pixel_checker
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pixels_due.size() == 0) begin
                note_failure($sformatf("pixel with none due: %s", pixel_text(m_data)));
            end else begin
                want = pixels_due.pop_front();
                if (m_data.out_luma !== want.out_luma || m_data.out_cb !== want.out_cb ||
                        m_data.out_cr !== want.out_cr || m_data.out_alpha !== want.out_alpha ||
                        m_data.out_luma_second !== want.out_luma_second ||
                        m_data.single_pixel !== want.single_pixel) begin
                    note_failure($sformatf("pixel mismatch: expected %s, got %s",
                                           pixel_text(want), pixel_text(m_data)));
                end
            end
        end
    end

    // Ends the run when no item moves on either side for too long.
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle = 0;
            else idle++;
        end
        $display("** bilinear_remap_pixel_sampler_top: FAILED **");
        $finish;
    end

    initial begin : main
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_blend_corners();
        test_output_modes();
        test_yuyv_packing();
        test_width_extremes();
        test_backpressure();
        test_random();
        settle();
        if (bad_count == 0 && pixels_due.size() == 0) begin
            $display("** bilinear_remap_pixel_sampler_top: PASSED **");
        end else begin
            $display("** bilinear_remap_pixel_sampler_top: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+rtl
rtl/brps_pkg.sv
rtl/brps_ram.sv
rtl/brps_front.sv
rtl/brps_queue.sv
rtl/brps_back.sv
rtl/bilinear_remap_pixel_sampler_top.sv
sim/tb_bilinear_remap_pixel_sampler_top.sv
